FILE: design/irtg_pkg.sv
package irtg_pkg;

	typedef enum logic [2:0] {
		EV_FRAME_START = 3'd0,
		EV_VSYNC_BEGIN = 3'd1,
		EV_VSYNC_END   = 3'd2,
		EV_HSYNC_BEGIN = 3'd3,
		EV_HSYNC_END   = 3'd4
	} event_kind_t;

	localparam int unsigned NUM_EVENTS = 5;

	typedef logic [2:0] reg_index_t;

	localparam reg_index_t REG_LINE_PERIOD  = 3'd0;
	localparam reg_index_t REG_HSYNC_WIDTH  = 3'd1;
	localparam reg_index_t REG_TOTAL_LINES  = 3'd2;
	localparam reg_index_t REG_HALF_LINES   = 3'd3;
	localparam reg_index_t REG_TOP_BLANK    = 3'd4;
	localparam reg_index_t REG_BOTTOM_BLANK = 3'd5;

	localparam logic [15:0] RST_LINE_PERIOD  = 16'd640;
	localparam logic [15:0] RST_HSYNC_WIDTH  = 16'd120;
	localparam logic [9:0]  RST_TOTAL_LINES  = 10'd625;
	localparam logic [8:0]  RST_HALF_LINES   = 9'd312;
	localparam logic [7:0]  RST_TOP_BLANK    = 8'd23;
	localparam logic [7:0]  RST_BOTTOM_BLANK = 8'd4;

	localparam int unsigned LACC_W = 20;
	localparam int unsigned SACC_W = 16;

endpackage

FILE: design/interlaced_raster_timing_generator.sv
// Interlaced raster timing generator.
// Slave stream: one word per tick, tdata[11:0] = clocks elapsed since the last tick.
// Master stream: one word per timing event, tlast marks the last event of a tick.
// Config channel: cfg_index selects the register (0 line_period, 1 hsync_width,
// 2 total_lines, 3 half_lines, 4 top_blank, 5 bottom_blank), cfg_data carries the
// value; it is always ready and writes to unknown indexes are dropped.
// A tick is folded into the line and sync accumulators in the cycle it is
// accepted; its events (up to five) sit in an output register from the next cycle
// and leave one word per cycle while m_tready is high, so a tick's first event appears
// in the cycle after acceptance and a tick with n events holds the output for n words.
// Ticks with no event or one event are taken every cycle while m_tready is high;
// a tick with more events holds the slave side until its last word is taken. The
// limit is the single output word per cycle.
// Reset clears the accumulators, line counters and pending events and loads the
// register defaults (640, 120, 625, 312, 23, 4). When m_tready is low the
// pending word holds and the slave side stalls while any event is pending.
module interlaced_raster_timing_generator #(
	parameter int unsigned LINE_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] elapsed
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] event_kind, [12:3] visible_line, [22:13] raster_line
	output logic        m_tlast,   // last event of the tick
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned L  = LINE_BITS;
	localparam int unsigned CW = ((L > 10) ? L : 10) + 2;
	localparam int unsigned LW = irtg_pkg::LACC_W;
	localparam int unsigned SW = irtg_pkg::SACC_W;
	localparam int unsigned NE = irtg_pkg::NUM_EVENTS;

	// configuration
	logic [15:0] line_period_q, hsync_width_q;
	logic [9:0]  total_lines_q;
	logic [8:0]  half_lines_q;
	logic [7:0]  top_blank_q, bottom_blank_q;

	// timing state
	logic [LW-1:0] line_accum_q;
	logic [SW-1:0] sync_accum_q;
	logic [L-1:0]  line_index_q, screen_index_q, sync_line_q;
	logic          sync_pulse_q;

	// event register
	logic [NE-1:0] pend_s1;
	logic [9:0]    vis_s1, ras_s1, sras_s1;

	logic          accept, m_fire, take;
	logic [11:0]   elapsed;
	logic [LW:0]   la_sum;
	logic [LW-1:0] la_sat, la_next;
	logic [SW-1:0] sa_base, sa_sat;
	logic [SW:0]   sa_sum;
	logic [L-1:0]  ln, half_l, diff, scr, ln_next;
	logic [L:0]    ln1;
	logic [9:0]    tot_m_bot;
	logic [8:0]    half_m_bot;
	logic [9:0]    half_p_top;
	logic          ev_vbeg, ev_vend, ev_hend, pulse_on;
	logic [NE-1:0] new_pend, pend_rest;
	irtg_pkg::event_kind_t cur_kind;
	logic [9:0]    cur_ras;

	assign cfg_ready = 1'b1;
	assign elapsed   = s_tdata[11:0];
	assign accept    = s_tvalid && s_tready;
	assign m_fire    = m_tvalid && m_tready;

	// line accumulator, saturating
	assign la_sum = {1'b0, line_accum_q} + (LW+1)'(elapsed);
	assign la_sat = la_sum[LW] ? {LW{1'b1}} : la_sum[LW-1:0];
	assign take   = la_sat >= LW'(line_period_q);
	assign la_next = take ? (la_sat - LW'(line_period_q)) : la_sat;

	// interlaced screen line
	assign ln     = line_index_q;
	assign half_l = L'(half_lines_q);
	assign diff   = ln - half_l - L'(1);
	always_comb begin
		if (CW'(ln) <= CW'(half_lines_q)) begin
			scr = {ln[L-2:0], 1'b0};
		end else begin
			scr = {diff[L-2:0], 1'b1};
		end
	end

	// vsync targets; a negative target never matches
	assign tot_m_bot  = total_lines_q - 10'(bottom_blank_q);
	assign half_m_bot = half_lines_q - 9'(bottom_blank_q);
	assign half_p_top = 10'(half_lines_q) + 10'(top_blank_q);
	assign ev_vbeg = (total_lines_q >= 10'(bottom_blank_q) && CW'(ln) == CW'(tot_m_bot)) ||
	                 (half_lines_q >= 9'(bottom_blank_q) && CW'(ln) == CW'(half_m_bot));
	assign ev_vend = (CW'(ln) == CW'(top_blank_q)) || (CW'(ln) == CW'(half_p_top));

	// raster line advance with wrap
	assign ln1     = {1'b0, ln} + (L+1)'(1);
	assign ln_next = (CW'(ln1) >= CW'(total_lines_q)) ? '0 : ln1[L-1:0];

	// sync accumulator restarts at hsync begin
	assign sa_base  = take ? '0 : sync_accum_q;
	assign sa_sum   = {1'b0, sa_base} + (SW+1)'(elapsed);
	assign sa_sat   = sa_sum[SW] ? {SW{1'b1}} : sa_sum[SW-1:0];
	assign pulse_on = take || sync_pulse_q;
	assign ev_hend  = pulse_on && (sa_sat >= hsync_width_q);

	always_comb begin
		new_pend = '0;
		new_pend[irtg_pkg::EV_FRAME_START] = take && (ln == '0);
		new_pend[irtg_pkg::EV_VSYNC_BEGIN] = take && ev_vbeg;
		new_pend[irtg_pkg::EV_VSYNC_END]   = take && ev_vend;
		new_pend[irtg_pkg::EV_HSYNC_BEGIN] = take;
		new_pend[irtg_pkg::EV_HSYNC_END]   = ev_hend;
	end

	// drop the lowest pending event once its word is taken
	assign pend_rest = pend_s1 & (pend_s1 - NE'(1));
	assign m_tvalid  = |pend_s1;
	assign m_tlast   = (pend_rest == '0);
	assign s_tready  = (pend_s1 == '0) || (m_tlast && m_tready);

	always_comb begin
		if (pend_s1[irtg_pkg::EV_FRAME_START]) begin
			cur_kind = irtg_pkg::EV_FRAME_START;
		end else if (pend_s1[irtg_pkg::EV_VSYNC_BEGIN]) begin
			cur_kind = irtg_pkg::EV_VSYNC_BEGIN;
		end else if (pend_s1[irtg_pkg::EV_VSYNC_END]) begin
			cur_kind = irtg_pkg::EV_VSYNC_END;
		end else if (pend_s1[irtg_pkg::EV_HSYNC_BEGIN]) begin
			cur_kind = irtg_pkg::EV_HSYNC_BEGIN;
		end else begin
			cur_kind = irtg_pkg::EV_HSYNC_END;
		end
	end

	assign cur_ras = (cur_kind == irtg_pkg::EV_HSYNC_END) ? sras_s1 : ras_s1;
	assign m_tdata = {1'b0, cur_ras, vis_s1, cur_kind};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_period_q  <= irtg_pkg::RST_LINE_PERIOD;
			hsync_width_q  <= irtg_pkg::RST_HSYNC_WIDTH;
			total_lines_q  <= irtg_pkg::RST_TOTAL_LINES;
			half_lines_q   <= irtg_pkg::RST_HALF_LINES;
			top_blank_q    <= irtg_pkg::RST_TOP_BLANK;
			bottom_blank_q <= irtg_pkg::RST_BOTTOM_BLANK;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				irtg_pkg::REG_LINE_PERIOD:  line_period_q  <= cfg_data;
				irtg_pkg::REG_HSYNC_WIDTH:  hsync_width_q  <= cfg_data;
				irtg_pkg::REG_TOTAL_LINES:  total_lines_q  <= cfg_data[9:0];
				irtg_pkg::REG_HALF_LINES:   half_lines_q   <= cfg_data[8:0];
				irtg_pkg::REG_TOP_BLANK:    top_blank_q    <= cfg_data[7:0];
				irtg_pkg::REG_BOTTOM_BLANK: bottom_blank_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_accum_q   <= '0;
			sync_accum_q   <= '0;
			line_index_q   <= '0;
			screen_index_q <= '0;
			sync_line_q    <= '0;
			sync_pulse_q   <= 1'b0;
			pend_s1        <= '0;
		end else begin
			if (accept) begin
				line_accum_q <= la_next;
				sync_accum_q <= sa_sat;
				sync_pulse_q <= pulse_on && !ev_hend;
				pend_s1      <= new_pend;
				if (take) begin
					line_index_q   <= ln_next;
					screen_index_q <= scr;
					sync_line_q    <= ln;
				end
			end else if (m_fire) begin
				pend_s1 <= pend_rest;
			end
		end
	end

	// event payload, loaded with each tick
	always_ff @(posedge clk) begin
		if (accept) begin
			vis_s1  <= take ? 10'(scr) : 10'(screen_index_q);
			ras_s1  <= 10'(ln);
			sras_s1 <= take ? 10'(ln) : 10'(sync_line_q);
		end
	end

endmodule

FILE: tb/raster_event_checker.sv
`timescale 1ns / 100ps

module raster_event_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] elapsed
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [2:0] event_kind, [12:3] visible_line, [22:13] raster_line
	input  logic        m_tlast,   // last event of the tick
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          bad_events,
	output int          events_owed
);

	localparam int unsigned ACC_MAX  = (1 << irtg_pkg::LACC_W) - 1;
	localparam int unsigned SYNC_MAX = (1 << irtg_pkg::SACC_W) - 1;

	typedef struct {
		irtg_pkg::event_kind_t kind;
		logic [9:0]            screen;
		logic [9:0]            raster;
		logic                  last;
	} raster_event_t;

	raster_event_t events_due [$];

	int unsigned period_cfg, hsync_cfg, lines_cfg, half_cfg, top_cfg, bottom_cfg;
	int unsigned line_acc, sync_acc;
	logic [9:0]  line_no, screen_no, pulse_line;
	bit          pulse_on;
	int          miss_count = 0;

	assign bad_events = miss_count;

	task automatic queue_event(input irtg_pkg::event_kind_t kind, input logic [9:0] screen,
			input logic [9:0] raster);
		raster_event_t ev;
		ev.kind   = kind;
		ev.screen = screen;
		ev.raster = raster;
		ev.last   = 1'b0;
		events_due.insert(events_due.size(), ev);
	endtask

	task automatic take_tick(input logic [11:0] elapsed);
		int unsigned   sum;
		int unsigned   ln;
		int            count_before;
		raster_event_t tail;
		count_before = events_due.size();
		sum = line_acc + elapsed;
		line_acc = (sum > ACC_MAX) ? ACC_MAX : sum;
		// at most one raster line per tick, the excess stays behind
		if (line_acc >= period_cfg) begin
			ln = line_no;
			line_acc = line_acc - period_cfg;
			if (ln <= half_cfg)
				screen_no = 10'(2 * ln);
			else
				screen_no = 10'(2 * (ln - half_cfg - 1) + 1);
			if (ln == 0)
				queue_event(irtg_pkg::EV_FRAME_START, screen_no, 10'(ln));
			// a target below zero never matches; two hits give one word
			if (int'(ln) == int'(lines_cfg) - int'(bottom_cfg) ||
					int'(ln) == int'(half_cfg) - int'(bottom_cfg))
				queue_event(irtg_pkg::EV_VSYNC_BEGIN, screen_no, 10'(ln));
			if (ln == top_cfg || ln == half_cfg + top_cfg)
				queue_event(irtg_pkg::EV_VSYNC_END, screen_no, 10'(ln));
			queue_event(irtg_pkg::EV_HSYNC_BEGIN, screen_no, 10'(ln));
			sync_acc   = 0;
			pulse_on   = 1'b1;
			pulse_line = 10'(ln);
			line_no    = (ln + 1 >= lines_cfg) ? 10'd0 : 10'(ln + 1);
		end
		sum = sync_acc + elapsed;
		sync_acc = (sum > SYNC_MAX) ? SYNC_MAX : sum;
		if (pulse_on && sync_acc >= hsync_cfg) begin
			queue_event(irtg_pkg::EV_HSYNC_END, screen_no, pulse_line);
			pulse_on = 1'b0;
		end
		if (events_due.size() > count_before) begin
			tail = events_due.pop_back();
			tail.last = 1'b1;
			events_due.insert(events_due.size(), tail);
		end
	endtask

	task automatic check_word;
		raster_event_t due;
		if (events_due.size() == 0) begin
			miss_count++;
			if (miss_count <= 10)
				$display("unexpected event word: kind %0d visible %0d raster %0d last %0b",
					m_tdata[2:0], m_tdata[12:3], m_tdata[22:13], m_tlast);
		end else begin
			due = events_due.pop_front();
			if (m_tdata[2:0] !== due.kind || m_tdata[12:3] !== due.screen ||
					m_tdata[22:13] !== due.raster || m_tlast !== due.last) begin
				miss_count++;
				if (miss_count <= 10)
					$display("event mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
						due.kind, due.screen, due.raster, due.last,
						m_tdata[2:0], m_tdata[12:3], m_tdata[22:13], m_tlast);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_cfg  = irtg_pkg::RST_LINE_PERIOD;
			hsync_cfg   = irtg_pkg::RST_HSYNC_WIDTH;
			lines_cfg   = irtg_pkg::RST_TOTAL_LINES;
			half_cfg    = irtg_pkg::RST_HALF_LINES;
			top_cfg     = irtg_pkg::RST_TOP_BLANK;
			bottom_cfg  = irtg_pkg::RST_BOTTOM_BLANK;
			line_acc    = 0;
			sync_acc    = 0;
			line_no     = '0;
			screen_no   = '0;
			pulse_line  = '0;
			pulse_on    = 1'b0;
			events_due.delete();
			events_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					irtg_pkg::REG_LINE_PERIOD:  period_cfg = cfg_data;
					irtg_pkg::REG_HSYNC_WIDTH:  hsync_cfg  = cfg_data;
					irtg_pkg::REG_TOTAL_LINES:  lines_cfg  = cfg_data[9:0];
					irtg_pkg::REG_HALF_LINES:   half_cfg   = cfg_data[8:0];
					irtg_pkg::REG_TOP_BLANK:    top_cfg    = cfg_data[7:0];
					irtg_pkg::REG_BOTTOM_BLANK: bottom_cfg = cfg_data[7:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				take_tick(s_tdata[11:0]);
			events_owed <= events_due.size();
		end
	end

endmodule

FILE: tb/tb_interlaced_raster_timing_generator.sv
`timescale 1ns / 100ps

module tb_interlaced_raster_timing_generator;

	localparam int WATCHDOG_LIMIT = 4000;
	// index with no register behind it, writes must be dropped
	localparam irtg_pkg::reg_index_t REG_SPARE = 3'd7;

	typedef enum logic [1:0] {RX_STEADY, RX_STALL, RX_CHOPPY} rx_pattern_t;
	typedef enum logic {MIX_SPREAD, MIX_HEAVY} tick_mix_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [11:0] elapsed
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // [2:0] event_kind, [12:3] visible_line, [22:13] raster_line
	logic        m_tlast;        // last event of the tick
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	irtg_pkg::reg_index_t cfg_index = irtg_pkg::REG_LINE_PERIOD;
	logic [15:0] cfg_data = '0;

	int          bad_events;
	int          events_owed;
	int          burst_left = 0;
	int unsigned cur_period = irtg_pkg::RST_LINE_PERIOD;
	rx_pattern_t rx_pattern = RX_STEADY;
	int          rx_left = 0;
	int          idle_cycles = 0;

	always #1 clk = ~clk;

	interlaced_raster_timing_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	raster_event_checker CHECK (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.bad_events  (bad_events),
		.events_owed (events_owed)
	);

	// receiver: steady, stalled or choppy stretches of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			rx_left    <= 0;
			rx_pattern <= RX_STEADY;
		end else if (rx_left == 0) begin
			rx_pattern <= rx_pattern_t'($urandom_range(0, 2));
			rx_left    <= $urandom_range(1, 30);
			m_tready   <= 1'b1;
		end else begin
			rx_left <= rx_left - 1;
			case (rx_pattern)
				RX_STEADY: m_tready <= 1'b1;
				RX_STALL:  m_tready <= 1'b0;
				default:   m_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_tick(input logic [11:0] elapsed);
		int gap;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, elapsed};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
	endtask

	// hold the sender until every event word is out and the block is quiet
	task automatic settle;
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (events_owed != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input irtg_pkg::reg_index_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_timing(input logic [15:0] period, input logic [15:0] width,
			input logic [15:0] lines, input logic [15:0] half, input logic [15:0] top,
			input logic [15:0] bottom);
		write_reg(REG_SPARE, 16'($urandom));
		write_reg(irtg_pkg::REG_LINE_PERIOD, period);
		write_reg(irtg_pkg::REG_HSYNC_WIDTH, width);
		write_reg(irtg_pkg::REG_TOTAL_LINES, lines);
		write_reg(irtg_pkg::REG_HALF_LINES, half);
		write_reg(irtg_pkg::REG_TOP_BLANK, top);
		write_reg(irtg_pkg::REG_BOTTOM_BLANK, bottom);
		cfg_valid <= 1'b0;
		cur_period = period;
	endtask

	task automatic random_timing;
		int unsigned lines;
		lines = $urandom_range(2, 40);
		load_timing(16'($urandom_range(1, 3000)), 16'($urandom_range(0, 4000)), 16'(lines),
			16'($urandom_range(1, lines)), 16'($urandom_range(0, lines)),
			16'($urandom_range(0, lines)));
	endtask

	function automatic logic [11:0] pick_elapsed(input tick_mix_t mix, input int idx);
		int unsigned span;
		span = (cur_period > 4095) ? 4095 : cur_period;
		if (mix == MIX_HEAVY)
			return (idx % 20 == 19) ? 12'($urandom_range(0, 4095))
				: 12'($urandom_range(3900, 4095));
		case ($urandom_range(0, 9))
			0:       return 12'd0;
			1:       return 12'hFFF;
			2, 3, 4: return 12'($urandom_range(0, 4095));
			default: return 12'($urandom_range(0, span));
		endcase
	endfunction

	task automatic run_ticks(input int count, input tick_mix_t mix);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				settle();
			send_tick(pick_elapsed(mix, i));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: quiet tick, line taken, hsync end, long ticks
		send_tick(12'd0);
		send_tick(12'd639);
		send_tick(12'd1);
		send_tick(12'd119);
		send_tick(12'hFFF);
		send_tick(12'hFFF);
		settle();
		// short frame, zero hsync width, vsync on both fields, wrap after last line
		load_timing(16'd2, 16'd0, 16'd6, 16'd2, 16'd1, 16'd1);
		repeat (8) send_tick(12'd1);
		settle();
		// frame shrinks below the current line; both vsync targets on one line
		load_timing(16'd2, 16'd0, 16'd3, 16'd3, 16'd1, 16'd1);
		repeat (4) send_tick(12'd1);
		settle();
		// vsync targets below zero
		load_timing(16'd2, 16'd0, 16'd3, 16'd3, 16'd1, 16'd9);
		repeat (3) send_tick(12'd1);
		settle();

		load_timing(16'd1, 16'd0, 16'd2, 16'd1, 16'd0, 16'd1);
		run_ticks(20, MIX_SPREAD);
		settle();
		random_timing();
		run_ticks(20, MIX_SPREAD);
		settle();
		load_timing(16'hFFFF, 16'hFFFF, 16'd1023, 16'd511, 16'd255, 16'd255);
		run_ticks(35, MIX_HEAVY);
		settle();
		random_timing();
		run_ticks(20, MIX_SPREAD);
		settle();
		random_timing();
		run_ticks(20, MIX_SPREAD);
		settle();
		// tiny period with long ticks takes a line on every tick and piles up the excess
		load_timing(16'd1, 16'($urandom_range(0, 8000)), 16'd1023,
			16'($urandom_range(1, 511)), 16'($urandom_range(0, 255)),
			16'($urandom_range(0, 255)));
		run_ticks(124, MIX_HEAVY);

		settle();
		repeat (12) @(posedge clk);
		if (bad_events == 0 && events_owed == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: files.f
design/irtg_pkg.sv
design/interlaced_raster_timing_generator.sv
tb/raster_event_checker.sv
tb/tb_interlaced_raster_timing_generator.sv
